FILE: rtl/core/bhbs_pkg.sv
// shared types and constants for the byte histogram bar scaler
package bhbs_pkg;

    typedef enum logic [1:0] {
        CMD_COUNT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [0:0] CFG_HEADER_BYTES = 1'b0;
    localparam logic [0:0] CFG_PLOT_HEIGHT  = 1'b1;

    localparam int          CFG_WIDTH     = 16;
    localparam logic [11:0] BAR_MARGIN    = 12'd10;
    localparam logic [15:0] POS_MAX       = 16'hffff;
    localparam logic [15:0] HEADER_RESET  = 16'd54;
    localparam logic [11:0] HEIGHT_RESET  = 12'd256;
    localparam int          BIN_BITS      = 8;
    localparam int          BAR_BITS      = 12;
    localparam int          OUT_CNT_BITS  = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_WAIT,
        ST_DIV,
        ST_OUT
    } back_state_t;

    // classified work handed from the front to the back
    typedef struct packed {
        cmd_t                cmd;
        logic                do_count;
        logic [BIN_BITS-1:0] bin;
    } job_t;

endpackage

FILE: rtl/core/bhbs_ram.sv
// generic single write port ram with registered read
module bhbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bhbs_front.sv
// front end: accepts transactions, tracks byte position, classifies work
module bhbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          bin_index,
    input  logic [15:0]         header_bytes,
    input  logic                q_full,
    output logic                q_push,
    output bhbs_pkg::job_t      q_data
);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        q_data.cmd      = bhbs_pkg::cmd_t'(command);
        q_data.do_count = pos_reg >= header_bytes;
        q_data.bin      = (command == bhbs_pkg::CMD_READ) ? bin_index : data_byte;
        q_push          = accept && (command != bhbs_pkg::CMD_NONE);
        pos_next        = pos_reg;
        if (accept && command == bhbs_pkg::CMD_COUNT && pos_reg != bhbs_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 16'd1;
        end
        else if (accept && command == bhbs_pkg::CMD_CLEAR)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/bhbs_queue.sv
// small fifo between front and back
module bhbs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bhbs_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bhbs_pkg::job_t head
);

    bhbs_pkg::job_t slot_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count out of range");
`endif

endmodule

FILE: rtl/core/bhbs_back.sv
// back end: bin memory read-modify-write, clear sweep, bar division, output register
module bhbs_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  bhbs_pkg::job_t      q_head,
    output logic                q_pop,
    input  logic [11:0]         plot_height,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          bin_number,
    output logic [31:0]         bin_count,
    output logic [11:0]         bar_height,
    output logic [31:0]         peak_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int PROD_BITS = COUNT_BITS + bhbs_pkg::BAR_BITS;
    localparam int STEP_BITS = $clog2(PROD_BITS + 1);

    bhbs_pkg::back_state_t state_reg, state_next;

    logic [bhbs_pkg::BIN_BITS-1:0] sweep_reg, sweep_next;
    logic [COUNT_BITS-1:0]         peak_reg, peak_next;

    // pipelined count stage: one count in flight, read last cycle
    logic                          p_valid_reg, p_valid_next;
    logic [bhbs_pkg::BIN_BITS-1:0] p_bin_reg;
    logic [COUNT_BITS-1:0]         fwd_val_reg;
    logic                          fwd_hit_reg;

    logic                          ram_we;
    logic [bhbs_pkg::BIN_BITS-1:0] ram_waddr;
    logic [COUNT_BITS-1:0]         ram_wdata;
    logic [bhbs_pkg::BIN_BITS-1:0] ram_raddr;
    logic [COUNT_BITS-1:0]         ram_rdata;

    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;

    // divider
    logic [PROD_BITS-1:0]  num_reg, num_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [COUNT_BITS-1:0] rcnt_reg, rcnt_next;
    logic [bhbs_pkg::BIN_BITS-1:0] rbin_reg, rbin_next;
    logic [COUNT_BITS:0]   rem_sh;
    logic [11:0]           scale;

    logic                  ov_reg, ov_next;
    logic [7:0]            o_bin_reg, o_bin_next;
    logic [31:0]           o_cnt_reg, o_cnt_next;
    logic [11:0]           o_bar_reg, o_bar_next;
    logic [31:0]           o_peak_reg, o_peak_next;

    bhbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(256)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_cnt = fwd_hit_reg ? fwd_val_reg : ram_rdata;
    assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    assign scale   = (plot_height < bhbs_pkg::BAR_MARGIN) ? 12'd0
                                                          : plot_height - bhbs_pkg::BAR_MARGIN;
    assign rem_sh  = {rem_reg[COUNT_BITS-1:0], num_reg[PROD_BITS-1]};

    assign out_valid  = ov_reg;
    assign bin_number = o_bin_reg;
    assign bin_count  = o_cnt_reg;
    assign bar_height = o_bar_reg;
    assign peak_count = o_peak_reg;

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        peak_next    = peak_reg;
        p_valid_next = 1'b0;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = p_bin_reg;
        ram_wdata    = inc_cnt;
        ram_raddr    = q_head.bin;
        num_next     = num_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        step_next    = step_reg;
        rcnt_next    = rcnt_reg;
        rbin_next    = rbin_reg;
        ov_next      = ov_reg && out_stall;
        o_bin_next   = o_bin_reg;
        o_cnt_next   = o_cnt_reg;
        o_bar_next   = o_bar_reg;
        o_peak_next  = o_peak_reg;

        // finish a count read last cycle
        if (p_valid_reg)
        begin
            ram_we = 1'b1;
            if (inc_cnt > peak_reg)
            begin
                peak_next = inc_cnt;
            end
        end

        case (state_reg)
            bhbs_pkg::ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    case (q_head.cmd)
                        bhbs_pkg::CMD_COUNT:
                        begin
                            q_pop        = 1'b1;
                            p_valid_next = q_head.do_count;
                        end
                        bhbs_pkg::CMD_READ:
                        begin
                            if (!p_valid_reg)
                            begin
                                q_pop      = 1'b1;
                                rbin_next  = q_head.bin;
                                state_next = bhbs_pkg::ST_RD_WAIT;
                            end
                        end
                        bhbs_pkg::CMD_CLEAR:
                        begin
                            if (!p_valid_reg)
                            begin
                                q_pop      = 1'b1;
                                sweep_next = '0;
                                peak_next  = '0;
                                state_next = bhbs_pkg::ST_CLEAR;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            bhbs_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    state_next = bhbs_pkg::ST_IDLE;
                end
            end
            bhbs_pkg::ST_RD_WAIT:
            begin
                rcnt_next  = ram_rdata;
                num_next   = ram_rdata * scale;
                rem_next   = '0;
                div_next   = (peak_reg == '0) ? {{(COUNT_BITS-1){1'b0}}, 1'b1} : peak_reg;
                step_next  = '0;
                state_next = bhbs_pkg::ST_DIV;
            end
            bhbs_pkg::ST_DIV:
            begin
                num_next = {num_reg[PROD_BITS-2:0], 1'b0};
                if (rem_sh >= {1'b0, div_reg})
                begin
                    rem_next    = rem_sh - {1'b0, div_reg};
                    num_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = rem_sh;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(PROD_BITS - 1))
                begin
                    state_next = bhbs_pkg::ST_OUT;
                end
            end
            bhbs_pkg::ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next     = 1'b1;
                    o_bin_next  = rbin_reg;
                    o_cnt_next  = 32'(rcnt_reg);
                    o_bar_next  = num_reg[11:0];
                    o_peak_next = 32'(peak_reg);
                    state_next  = bhbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bhbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_bin_reg   <= q_head.bin;
        fwd_hit_reg <= p_valid_reg && p_valid_next && (p_bin_reg == q_head.bin);
        fwd_val_reg <= inc_cnt;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        rcnt_reg    <= rcnt_next;
        rbin_reg    <= rbin_next;
        o_bin_reg   <= o_bin_next;
        o_cnt_reg   <= o_cnt_next;
        o_bar_reg   <= o_bar_next;
        o_peak_reg  <= o_peak_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bhbs_pkg::ST_CLEAR;
            sweep_reg   <= '0;
            peak_reg    <= '0;
            p_valid_reg <= 1'b0;
            step_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            peak_reg    <= peak_next;
            p_valid_reg <= p_valid_next;
            step_reg    <= step_next;
            ov_reg      <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_count) && $stable(bar_height))
        else $error("stalled result changed");
    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bhbs_pkg::ST_CLEAR |-> !q_pop)
        else $error("queue popped during clear sweep");
    a_read_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bhbs_pkg::ST_RD_WAIT |-> !p_valid_reg)
        else $error("read overlaps pending count write");
`endif

endmodule

FILE: rtl/core/byte_histogram_bar_scaler_unit.sv
// top level of the byte histogram bar scaler
//
// input channel: in_valid/in_stall carry command, data_byte and bin_index.
// command 0 counts data_byte (after the first header_bytes bytes since the
// last clear), 1 reads a bin, 2 clears everything; 3 is dropped.
// output channel: out_valid/out_stall carry one transaction per read command:
// bin_number, bin_count, bar_height = count*(plot_height-10)/peak, peak_count.
// counts run one per cycle while the back end is idle: a registered ram read, then an incrementing write
// with forwarding for back-to-back hits on the same bin.
// a read goes through the bit-serial divider, which
// forms the bar height one quotient bit a cycle.
// a clear sweeps all 256 bins, one bin a cycle.
// after reset the same sweep zeroes the bins; items queue meanwhile.
// a four-entry queue parts front and back; when it fills, in_stall rises.
// when out_stall holds a result, the result stays and later reads wait.
// configuration writes (cfg_we, cfg_index, cfg_data) act at once; issue them only while idle.
module byte_histogram_bar_scaler_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  bin_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  bin_number,
    output logic [31:0] bin_count,
    output logic [11:0] bar_height,
    output logic [31:0] peak_count
);

    logic [15:0] header_bytes_reg;
    logic [11:0] plot_height_reg;

    logic           q_full;
    logic           q_push;
    bhbs_pkg::job_t q_in;
    logic           q_pop;
    logic           q_not_empty;
    bhbs_pkg::job_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= bhbs_pkg::HEADER_RESET;
            plot_height_reg  <= bhbs_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bhbs_pkg::CFG_HEADER_BYTES)
            begin
                header_bytes_reg <= cfg_data;
            end
            else
            begin
                plot_height_reg <= cfg_data[11:0];
            end
        end
    end

    bhbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data_byte    (data_byte),
        .bin_index    (bin_index),
        .header_bytes (header_bytes_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    bhbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bhbs_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .plot_height (plot_height_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_number  (bin_number),
        .bin_count   (bin_count),
        .bar_height  (bar_height),
        .peak_count  (peak_count)
    );

endmodule

FILE: bench/bhbs_histogram_checker.sv
// checker: mirrors the histogram state and compares every read transaction
module bhbs_histogram_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  bin_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  bin_number,
    input  logic [31:0] bin_count,
    input  logic [11:0] bar_height,
    input  logic [31:0] peak_count,
    output int          fail_count,
    output int          reads_pending
);

    typedef struct packed {
        logic [7:0]  bin;
        logic [31:0] count;
        logic [11:0] bar;
        logic [31:0] peak;
    } bin_read_t;

    logic [31:0] hist [256];
    logic [31:0] peak_seen;
    logic [15:0] position;
    logic [15:0] skip_bytes;
    logic [11:0] chart_height;
    bin_read_t   expected_reads [$];

    assign reads_pending = expected_reads.size();

    function automatic logic [11:0] bar_height_of(logic [31:0] cnt);
        logic [63:0] prod;
        logic [63:0] div;
        if (chart_height < bhbs_pkg::BAR_MARGIN)
            return '0;
        prod = 64'(cnt) * 64'(chart_height - bhbs_pkg::BAR_MARGIN);
        div = (peak_seen == 0) ? 64'd1 : 64'(peak_seen);
        return 12'(prod / div);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_read_t rd;
        logic [31:0] c;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
                hist[i] = '0;
            peak_seen = '0;
            position = '0;
            skip_bytes = bhbs_pkg::HEADER_RESET;
            chart_height = bhbs_pkg::HEIGHT_RESET;
            expected_reads.delete();
            fail_count = 0;
        end
        else
        begin
            // result side first: it reflects only earlier transactions
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    report("unexpected result transaction", 64'(bin_number), 64'd0);
                end
                else
                begin
                    rd = expected_reads.pop_front();
                    if (bin_number !== rd.bin)  report("bin_number", bin_number, rd.bin);
                    if (bin_count !== rd.count) report("bin_count", bin_count, rd.count);
                    if (bar_height !== rd.bar)  report("bar_height", bar_height, rd.bar);
                    if (peak_count !== rd.peak) report("peak_count", peak_count, rd.peak);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == bhbs_pkg::CFG_HEADER_BYTES)
                    skip_bytes = cfg_data;
                else
                    chart_height = cfg_data[11:0];
            end
            if (in_valid && !in_stall)
            begin
                case (bhbs_pkg::cmd_t'(command))
                    bhbs_pkg::CMD_COUNT:
                    begin
                        if (position >= skip_bytes)
                        begin
                            c = hist[data_byte];
                            if (c != 32'hffff_ffff)
                                c = c + 1;
                            hist[data_byte] = c;
                            if (c > peak_seen)
                                peak_seen = c;
                        end
                        if (position != bhbs_pkg::POS_MAX)
                            position = position + 1;
                    end
                    bhbs_pkg::CMD_READ:
                    begin
                        rd.bin = bin_index;
                        rd.count = hist[bin_index];
                        rd.bar = bar_height_of(hist[bin_index]);
                        rd.peak = peak_seen;
                        expected_reads.push_back(rd);
                    end
                    bhbs_pkg::CMD_CLEAR:
                    begin
                        for (int i = 0; i < 256; i++)
                            hist[i] = '0;
                        peak_seen = '0;
                        position = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/tb_byte_histogram_bar_scaler_unit.sv
// testbench top: stimulus, receiver stalls, watchdog and verdict
module tb_byte_histogram_bar_scaler_unit;

    localparam int IDLE_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 1400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [7:0]  bin_index;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  bin_number;
    logic [31:0] bin_count;
    logic [11:0] bar_height;
    logic [31:0] peak_count;
    int          fail_count;
    int          reads_pending;
    logic        hold_req;
    int          burst_left;
    int          idle_cycles;

    byte_histogram_bar_scaler_unit dut (.*);

    bhbs_histogram_checker checker_i (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: changing stall pattern plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold_cnt;
        int mode;
        int mode_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt = 0;
            mode = 0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 80);
            end
            mode_left--;
            if (hold_req)
                hold_cnt = 600;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (mode == 0)
                out_stall <= 1'b0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 1) == 1);
            else
                out_stall <= ($urandom_range(0, 9) < 8);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic push(bhbs_pkg::cmd_t cmd, logic [7:0] data, logic [7:0] idx,
                        bit gaps = 1);
        if (gaps && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= data;
        bin_index <= idx;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (reads_pending != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int n, int hot_bins);
        int r;
        logic [7:0] d;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            d = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, hot_bins)) : 8'($urandom);
            if (r < 72)
                push(bhbs_pkg::CMD_COUNT, d, 8'($urandom));
            else if (r < 92)
                push(bhbs_pkg::CMD_READ, 8'($urandom),
                     ($urandom_range(0, 1) == 1) ? d : 8'($urandom));
            else if (r < 95)
                push(bhbs_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
            else
                push(bhbs_pkg::CMD_NONE, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bhbs_pkg::CFG_HEADER_BYTES;
        cfg_data <= '0;
        in_valid <= 1'b0;
        command <= bhbs_pkg::CMD_NONE;
        data_byte <= '0;
        bin_index <= '0;
        hold_req <= 1'b0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // reset settings: header skip of 54 bytes
        for (int k = 0; k < 60; k++)
            push(bhbs_pkg::CMD_COUNT, 8'(k % 3), 8'hff);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'd0);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'd2);
        push(bhbs_pkg::CMD_NONE, 8'hff, 8'hff);
        push(bhbs_pkg::CMD_READ, 8'hff, 8'd1);
        settle();

        // no header, tallest chart, byte and bin extremes
        write_reg(bhbs_pkg::CFG_HEADER_BYTES, 16'd0);
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'd4095);
        push(bhbs_pkg::CMD_CLEAR, 8'h00, 8'h00);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'hff);
        push(bhbs_pkg::CMD_COUNT, 8'hff, 8'h00);
        push(bhbs_pkg::CMD_COUNT, 8'hff, 8'h00);
        push(bhbs_pkg::CMD_COUNT, 8'h00, 8'h00);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'hff);
        push(bhbs_pkg::CMD_READ, 8'hff, 8'h00);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'h80);
        push(bhbs_pkg::CMD_CLEAR, 8'hff, 8'hff);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'hff);
        settle();

        // flat chart and a chart below the margin
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'd10);
        push(bhbs_pkg::CMD_COUNT, 8'h55, 8'h00);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'h55);
        settle();
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'hf005);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'h55);
        settle();

        // random phases over several settings
        write_reg(bhbs_pkg::CFG_HEADER_BYTES, 16'd3);
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'd256);
        random_items(120, 3);
        settle();
        write_reg(bhbs_pkg::CFG_HEADER_BYTES, 16'($urandom_range(0, 40)));
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'($urandom));
        random_items(120, 15);

        // long receiver hold while reads keep coming
        in_valid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int k = 0; k < 30; k++)
            push(bhbs_pkg::CMD_READ, 8'($urandom), 8'($urandom), 0);
        settle();
        write_reg(bhbs_pkg::CFG_HEADER_BYTES, 16'($urandom_range(0, 8)));
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'($urandom_range(11, 4095)));
        random_items(150, 1);
        settle();

        // header at its maximum: nothing is counted
        write_reg(bhbs_pkg::CFG_HEADER_BYTES, 16'hffff);
        write_reg(bhbs_pkg::CFG_PLOT_HEIGHT, 16'd4095);
        push(bhbs_pkg::CMD_CLEAR, 8'h00, 8'h00);
        for (int k = 0; k < 20; k++)
            push(bhbs_pkg::CMD_COUNT, 8'($urandom_range(7, 8)), 8'($urandom), 0);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'd7);
        push(bhbs_pkg::CMD_READ, 8'h00, 8'd8);
        settle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
